### src/rtt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Repeating timer table package
// Shared item types, command codes and controller interface structs.
// ----------------------------------------------------------------------------
package rtt_pkg;

    localparam logic [2:0] OP_ADD        = 3'd0;
    localparam logic [2:0] OP_REMOVE     = 3'd1;
    localparam logic [2:0] OP_REMOVE_ALL = 3'd2;
    localparam logic [2:0] OP_SET_LEFT   = 3'd3;
    localparam logic [2:0] OP_SET_PERIOD = 3'd4;
    localparam logic [2:0] OP_QUERY      = 3'd5;
    localparam logic [2:0] OP_TICK       = 3'd6;
    localparam logic [2:0] OP_UNUSED     = 3'd7;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] event_type;
        logic [30:0] time_value;
        logic [15:0] repeat_count;
        logic        unconditional;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [3:0]  slot;
        logic [15:0] fired_type;
        logic        found;
        logic        full_res;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic step;
        logic clear_found;
    } dp_cmd_t;

    typedef struct packed {
        logic walk_done;
        logic fire;
        logic found;
        logic full;
    } dp_status_t;

endpackage

### src/repeating_timer_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Repeating timer table unit
// A bank of typed repeating timers with add, remove, modify, query and tick.
// ----------------------------------------------------------------------------
//  Channel   Signals                          Direction
//  in        in_valid / in_ready / in_item    into the block
//  out       out_valid / out_ready / out_item out of the block
//
//  Add and unknown commands complete without a slot walk; every other command
//  walks all SLOTS entries, one per cycle, and then emits its completion. The
//  walk advances only while the output register is free, so a stalled output
//  stalls the walk. Reset clears all slot valid bits.
// ----------------------------------------------------------------------------
module repeating_timer_table_unit
    import rtt_pkg::*;
#(
    parameter int SLOTS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    dp_cmd_t     cmd;
    dp_status_t  status;
    logic [3:0]  cur_slot;
    logic [15:0] cur_type;

    rtt_datapath #(.SLOTS(SLOTS)) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (in_item),
        .cmd      (cmd),
        .status   (status),
        .cur_slot (cur_slot),
        .cur_type (cur_type)
    );

    rtt_control u_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_op     (in_item.op),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cmd       (cmd),
        .status    (status),
        .cur_slot  (cur_slot),
        .cur_type  (cur_type)
    );

    a_ready_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (!out_valid || out_ready))
        else $error("Input ready while an output item is blocked");

    a_fire_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.kind) |-> !out_item.last)
        else $error("Fire item marked last");

    a_full_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_item.full_res && out_item.found))
        else $error("Full and found together");

endmodule

### src/rtt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Repeating timer table datapath
// Slot storage, the slot walk counter, and per-slot update logic.
// ----------------------------------------------------------------------------
module rtt_datapath
    import rtt_pkg::*;
#(
    parameter int SLOTS = 16,
    parameter int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  in_item_t   item,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    output logic [3:0] cur_slot,
    output logic [15:0] cur_type
);

    logic [SLOTS-1:0] valid_reg;
    logic [15:0] type_mem [SLOTS];
    logic [30:0] period_mem [SLOTS];
    logic [30:0] remain_mem [SLOTS];
    logic [15:0] repeat_mem [SLOTS];
    in_item_t     item_reg;
    logic [IW-1:0] idx_reg;
    logic          found_reg;
    logic          found_next;

    logic          v;
    logic          match;
    logic          expired;
    logic [15:0]   rep_dec;
    logic          ops_match;
    logic [IW-1:0] free_idx;
    logic          any_free;

    always_comb
    begin
        free_idx = '0;
        any_free = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = IW'(i);
                any_free = 1'b1;
            end
        end
    end

    assign v         = valid_reg[idx_reg];
    assign match     = v && (type_mem[idx_reg] == item_reg.event_type);
    assign expired   = v && (remain_mem[idx_reg] <= item_reg.time_value);
    assign rep_dec   = repeat_mem[idx_reg] - 16'd1;
    assign ops_match = (item_reg.op inside {OP_REMOVE, OP_SET_LEFT, OP_SET_PERIOD, OP_QUERY});

    always_comb
    begin
        found_next = found_reg;
        if (cmd.clear_found)
            found_next = 1'b0;
        else if (cmd.step)
        begin
            case (item_reg.op)
                OP_REMOVE_ALL: found_next = found_reg | v;
                OP_TICK:       found_next = found_reg | expired;
                default:       found_next = found_reg | (ops_match & match);
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            idx_reg   <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
            if (cmd.load)
            begin
                idx_reg <= '0;
                if (item.op == OP_ADD && any_free)
                    valid_reg[free_idx] <= 1'b1;
            end
            else if (cmd.step)
            begin
                idx_reg <= idx_reg + IW'(1);
                case (item_reg.op)
                    OP_REMOVE:     if (match) valid_reg[idx_reg] <= 1'b0;
                    OP_REMOVE_ALL: valid_reg[idx_reg] <= 1'b0;
                    OP_TICK:
                        if (expired && repeat_mem[idx_reg] != 16'd0 && rep_dec == 16'd0)
                            valid_reg[idx_reg] <= 1'b0;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
            if (item.op == OP_ADD && any_free)
            begin
                type_mem[free_idx]   <= item.event_type;
                period_mem[free_idx] <= item.time_value;
                remain_mem[free_idx] <= item.time_value;
                repeat_mem[free_idx] <= item.repeat_count;
            end
        end
        else if (cmd.step)
        begin
            case (item_reg.op)
                OP_SET_LEFT:
                    if (match)
                        remain_mem[idx_reg] <= (item_reg.unconditional ||
                            item_reg.time_value <= period_mem[idx_reg]) ?
                            item_reg.time_value : period_mem[idx_reg];
                OP_SET_PERIOD:
                    if (match)
                    begin
                        period_mem[idx_reg] <= item_reg.time_value;
                        remain_mem[idx_reg] <= item_reg.time_value;
                    end
                OP_TICK:
                    if (v)
                    begin
                        if (expired)
                        begin
                            remain_mem[idx_reg] <= period_mem[idx_reg];
                            if (repeat_mem[idx_reg] != 16'd0)
                                repeat_mem[idx_reg] <= rep_dec;
                        end
                        else
                            remain_mem[idx_reg] <= remain_mem[idx_reg] - item_reg.time_value;
                    end
                default: ;
            endcase
        end
    end

    assign status.walk_done = (idx_reg == IW'(SLOTS - 1));
    assign status.fire      = (item_reg.op == OP_TICK) && expired;
    assign status.found     = found_reg;
    assign status.full      = !any_free;
    assign cur_slot         = 4'(cmd.load ? free_idx : idx_reg);
    assign cur_type         = type_mem[idx_reg];

endmodule

### src/rtt_control.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Repeating timer table controller
// Sequences handshakes, the slot walk and result item generation.
// ----------------------------------------------------------------------------
module rtt_control
    import rtt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  in_op,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_item,
    output dp_cmd_t     cmd,
    input  dp_status_t  status,
    input  logic [3:0]  cur_slot,
    input  logic [15:0] cur_type
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic        oval_reg;
    out_item_t   out_reg;
    logic        out_free;
    logic        accept;
    logic        walk_op;
    logic        add_op;

    assign out_free = !oval_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign accept   = in_valid && in_ready;
    assign walk_op  = (in_op inside {OP_REMOVE, OP_REMOVE_ALL, OP_SET_LEFT,
                                     OP_SET_PERIOD, OP_QUERY, OP_TICK});
    assign add_op   = (in_op == OP_ADD);

    always_comb
    begin
        cmd             = '0;
        state_next      = state_reg;
        cmd.load        = accept;
        cmd.clear_found = accept;
        case (state_reg)
            S_IDLE:
                if (accept && walk_op)
                    state_next = S_WALK;
            S_WALK:
                if (out_free)
                begin
                    cmd.step = 1'b1;
                    if (status.walk_done)
                        state_next = S_DONE;
                end
            S_DONE:
                if (out_free)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_free)
                oval_reg <= (accept && !walk_op) ||
                            (state_reg == S_WALK && status.fire) ||
                            (state_reg == S_DONE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_reg <= '0;
            if (accept)
            begin
                out_reg.last     <= 1'b1;
                out_reg.found    <= add_op && !status.full;
                out_reg.full_res <= add_op && status.full;
                out_reg.slot     <= (add_op && !status.full) ? cur_slot : 4'd0;
            end
            else if (state_reg == S_WALK)
            begin
                out_reg.kind       <= 1'b1;
                out_reg.slot       <= cur_slot;
                out_reg.fired_type <= cur_type;
            end
            else if (state_reg == S_DONE)
            begin
                out_reg.last  <= 1'b1;
                out_reg.found <= status.found;
            end
        end
    end

    assign out_valid = oval_reg;
    assign out_item  = out_reg;

endmodule
